### hdl/far_pkg.sv
// shared types and constants of the fraction arithmetic reduce unit
`timescale 1ns / 1ps
`default_nettype none
package far_pkg;
    localparam int OperandBits  = 28;
    localparam int ResBits      = 56;
    localparam int MagBits      = 55;
    localparam logic [OperandBits-1:0] MaxMagnitude = OperandBits'(100000000);

    localparam logic [1:0] ModeAdd = 2'd0;
    localparam logic [1:0] ModeSub = 2'd1;
    localparam logic [1:0] ModeMul = 2'd2;
    localparam logic [1:0] ModeDiv = 2'd3;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusRange = 2'd1;
    localparam logic [1:0] StatusZero  = 2'd2;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]               mode;
        logic                     bad;
        logic signed [OperandBits-1:0] na;
        logic signed [OperandBits-1:0] da;
        logic signed [OperandBits-1:0] nb;
        logic signed [OperandBits-1:0] db;
    } t_job;
endpackage
`default_nettype wire

### hdl/fraction_arith_reduce_unit.sv
// top level of the fraction arithmetic reduce unit
`timescale 1ns / 1ps
`default_nettype none
// takes two signed fractions and an operation code, forms the cross products and returns the
// result reduced by the gcd of the magnitudes; the front end range-checks operands into a
// two-word queue, the back end forms the products in S_MUL1 and S_MUL2, sums them in S_SUM,
// runs a binary gcd and two 55-step restoring divisions; an out-of-range word goes straight
// to S_OUT, and a zero numerator or zero denominator goes to S_OUT once the gcd has loaded the
// magnitudes; the back end works on one word at a time and takes the next one the cycle
// after its result has been accepted
module fraction_arith_reduce_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic signed [27:0] i_num_a,
    input  wire logic signed [27:0] i_den_a,
    input  wire logic signed [27:0] i_num_b,
    input  wire logic signed [27:0] i_den_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [55:0] o_res_num,
    output logic signed [55:0] o_res_den,
    output logic [1:0]       o_status
);
    // queue handshake between the parts
    logic          w_job_valid, w_job_take;
    far_pkg::t_job w_job;

    far_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_num_a, .i_den_a, .i_num_b,
        .i_den_b, .o_job_valid(w_job_valid), .i_job_take(w_job_take), .o_job(w_job)
    );

    far_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .o_job_take(w_job_take),
        .i_job(w_job), .o_valid, .i_stall, .o_res_num, .o_res_den, .o_status
    );

`ifndef SYNTHESIS
    // a zero numerator always comes out over one
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == far_pkg::StatusOk && o_res_num == '0 |-> o_res_den == 56'sd1)
        else $error("zero numerator not over one");
    // error words carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != far_pkg::StatusOk |-> o_res_num == '0 && o_res_den == '0)
        else $error("error word with payload");
    // status never takes the unused code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == far_pkg::StatusOk || o_status == far_pkg::StatusRange ||
                     o_status == far_pkg::StatusZero))
        else $error("bad status");
`endif
endmodule
`default_nettype wire

### hdl/far_front.sv
// front end: range check of the operands and a two-entry job queue
`timescale 1ns / 1ps
`default_nettype none
module far_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic signed [far_pkg::OperandBits-1:0] i_num_a,
    input  wire logic signed [far_pkg::OperandBits-1:0] i_den_a,
    input  wire logic signed [far_pkg::OperandBits-1:0] i_num_b,
    input  wire logic signed [far_pkg::OperandBits-1:0] i_den_b,
    output logic                     o_job_valid,
    input  wire logic                i_job_take,
    output far_pkg::t_job            o_job
);
    far_pkg::t_job r_q [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    function automatic logic oor(input logic signed [far_pkg::OperandBits-1:0] x);
        logic [far_pkg::OperandBits-1:0] m;
        m = x[far_pkg::OperandBits-1] ? -x : x;
        return x[far_pkg::OperandBits-1] ? (m > far_pkg::MaxMagnitude || m == '0)
                                          : (m > far_pkg::MaxMagnitude);
    endfunction

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr].mode <= i_mode;
            r_q[r_wr].bad  <= oor(i_num_a) || oor(i_den_a) || oor(i_num_b) || oor(i_den_b);
            r_q[r_wr].na   <= i_num_a;
            r_q[r_wr].da   <= i_den_a;
            r_q[r_wr].nb   <= i_num_b;
            r_q[r_wr].db   <= i_den_b;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

### hdl/far_back.sv
// back end: cross products, binary gcd and restoring divisions
`timescale 1ns / 1ps
`default_nettype none
module far_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_take,
    input  wire far_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic signed [far_pkg::ResBits-1:0] o_res_num,
    output logic signed [far_pkg::ResBits-1:0] o_res_den,
    output logic [1:0]         o_status
);
    localparam int RB = far_pkg::ResBits;
    localparam int MB = far_pkg::MagBits;
    localparam int CB = $clog2(MB + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001, S_MUL1 = 8'b0000_0010, S_MUL2 = 8'b0000_0100,
        S_SUM  = 8'b0000_1000, S_GCD  = 8'b0001_0000, S_DIVN = 8'b0010_0000,
        S_DIVD = 8'b0100_0000, S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    far_pkg::t_job r_job;
    logic signed [RB-1:0] r_p0, r_p1, r_p2, r_n, r_d;
    logic [MB-1:0] r_a, r_b, r_g, r_quo, r_rem, r_dvd;
    logic [CB-1:0] r_sh, r_cnt;
    logic r_nneg, r_dneg;
    logic signed [far_pkg::OperandBits-1:0] w_x0, w_y0, w_x1, w_y1;
    logic [MB-1:0] w_an, w_ad, w_rem2;
    logic signed [RB-1:0] w_sum;
    logic [MB:0] w_sub;

    assign o_job_take = (r_state == S_IDLE) && !o_valid;

    always_comb begin
        case (r_job.mode)
            far_pkg::ModeMul: begin w_x0 = r_job.na; w_y0 = r_job.nb; end
            default:          begin w_x0 = r_job.na; w_y0 = r_job.db; end
        endcase
        w_x1 = r_job.da;
        w_y1 = (r_job.mode == far_pkg::ModeDiv) ? r_job.nb : r_job.db;
        case (r_job.mode)
            far_pkg::ModeAdd: w_sum = r_p0 + r_p2;
            far_pkg::ModeSub: w_sum = r_p0 - r_p2;
            default:          w_sum = r_p0;
        endcase
        w_an   = MB'(r_n[RB-1] ? -r_n : r_n);
        w_ad   = MB'(r_d[RB-1] ? -r_d : r_d);
        w_rem2 = {r_rem[MB-2:0], r_dvd[MB-1]};
        w_sub  = {1'b0, w_rem2} - {1'b0, r_g};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_job_valid && o_job_take) begin
                    r_job   <= i_job;
                    r_state <= i_job.bad ? S_OUT : S_MUL1;
                end
                S_MUL1: begin
                    r_p0 <= RB'(w_x0) * RB'(w_y0);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1 <= RB'(w_x1) * RB'(w_y1);
                    r_p2 <= RB'(r_job.da) * RB'(r_job.nb);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_n <= w_sum;
                    r_d <= r_p1;
                    r_state <= S_GCD;
                    r_sh <= '0;
                    r_a <= '0;
                    r_b <= '0;
                    r_cnt <= '1;
                end
                S_GCD: begin
                    if (r_cnt == '1) begin
                        // load magnitudes once
                        r_a <= w_an; r_b <= w_ad; r_cnt <= '0;
                        r_nneg <= r_n[RB-1]; r_dneg <= r_d[RB-1];
                        if (r_n == '0 || r_d == '0) r_state <= S_OUT;
                    end else if (r_a == '0 || r_b == '0) begin
                        r_g <= (r_a | r_b) << r_sh;
                        r_dvd <= w_an; r_rem <= '0; r_quo <= '0;
                        r_cnt <= CB'(MB);
                        r_state <= S_DIVN;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1; r_b <= r_b >> 1; r_sh <= r_sh + 1'b1;
                    end else if (!r_a[0]) r_a <= r_a >> 1;
                    else if (!r_b[0]) r_b <= r_b >> 1;
                    else if (r_a >= r_b) r_a <= (r_a - r_b) >> 1;
                    else r_b <= (r_b - r_a) >> 1;
                end
                S_DIVN, S_DIVD: begin
                    if (r_cnt == CB'(1)) begin
                        if (r_state == S_DIVN) begin
                            r_a <= w_sub[MB] ? {r_quo[MB-2:0], 1'b0}
                                             : {r_quo[MB-2:0], 1'b1};
                            r_dvd <= w_ad; r_rem <= '0; r_quo <= '0;
                            r_cnt <= CB'(MB);
                            r_state <= S_DIVD;
                        end else begin
                            r_b <= w_sub[MB] ? {r_quo[MB-2:0], 1'b0}
                                             : {r_quo[MB-2:0], 1'b1};
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (!w_sub[MB]) begin
                            r_rem <= w_sub[MB-1:0]; r_quo <= {r_quo[MB-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2; r_quo <= {r_quo[MB-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_OUT: if (!o_valid || !i_stall) begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_job.bad) begin
                        o_res_num <= '0; o_res_den <= '0; o_status <= far_pkg::StatusRange;
                    end else if (r_n == '0) begin
                        o_res_num <= '0; o_res_den <= RB'(1); o_status <= far_pkg::StatusOk;
                    end else if (r_d == '0) begin
                        o_res_num <= '0; o_res_den <= '0; o_status <= far_pkg::StatusZero;
                    end else begin
                        o_res_num <= r_nneg ? -RB'(r_a) : RB'(r_a);
                        o_res_den <= r_dneg ? -RB'(r_b) : RB'(r_b);
                        o_status  <= far_pkg::StatusOk;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### dv/tb_fraction_arith_reduce_unit.sv
// self-checking testbench of the fraction arithmetic reduce unit
`timescale 1ns / 1ps
`default_nettype none
module tb_fraction_arith_reduce_unit;
    localparam int CycleLimit = 2000000;
    localparam int TailCycles = 300;
    localparam longint MaxMag = 100000000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] na;
        logic [27:0] da;
        logic [27:0] nb;
        logic [27:0] db;
    } t_operands;

    typedef struct packed {
        logic [55:0] num;
        logic [55:0] den;
        logic [1:0]  status;
    } t_fraction;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [1:0]  i_mode = far_pkg::ModeAdd;
    logic [27:0] i_num_a = '0;
    logic [27:0] i_den_a = '0;
    logic [27:0] i_num_b = '0;
    logic [27:0] i_den_b = '0;
    logic        o_stall;
    logic        o_valid;
    logic [55:0] o_res_num;
    logic [55:0] o_res_den;
    logic [1:0]  o_status;

    t_operands pending_words[$];
    t_fraction expected_fractions[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_for_drain = 1'b0;

    fraction_arith_reduce_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_mode   (i_mode),
        .i_num_a  (i_num_a),
        .i_den_a  (i_den_a),
        .i_num_b  (i_num_b),
        .i_den_b  (i_den_b),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res_num(o_res_num),
        .o_res_den(o_res_den),
        .o_status (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    // exact rational result, reduced by the gcd of the magnitudes
    function automatic t_fraction reduce_fraction(t_operands w);
        t_fraction r;
        longint na, da, nb, db, n, d;
        longint unsigned a, b, t;
        na = longint'(signed'(w.na));
        da = longint'(signed'(w.da));
        nb = longint'(signed'(w.nb));
        db = longint'(signed'(w.db));
        r = '0;
        if (magnitude(na) > MaxMag || magnitude(da) > MaxMag ||
            magnitude(nb) > MaxMag || magnitude(db) > MaxMag) begin
            r.status = far_pkg::StatusRange;
            return r;
        end
        case (w.mode)
            far_pkg::ModeAdd: begin n = na * db + da * nb; d = da * db; end
            far_pkg::ModeSub: begin n = na * db - da * nb; d = da * db; end
            far_pkg::ModeMul: begin n = na * nb; d = da * db; end
            default: begin n = na * db; d = da * nb; end
        endcase
        if (n == 0) begin
            r.den = 56'd1;
            r.status = far_pkg::StatusOk;
            return r;
        end
        if (d == 0) begin
            r.status = far_pkg::StatusZero;
            return r;
        end
        a = magnitude(n);
        b = magnitude(d);
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        n = n / longint'(a);
        d = d / longint'(a);
        r.num = n[55:0];
        r.den = d[55:0];
        r.status = far_pkg::StatusOk;
        return r;
    endfunction

    function automatic logic [27:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return 28'(100000000);
            1: return 28'(-100000000);
            2: return 28'(100000001);
            3: return 28'(-100000001);
            4: return 28'h7ffffff;
            5: return 28'h8000000;
            6: return '0;
            7: return 28'($urandom);
            8, 9: return 28'($urandom_range(0, 40)) - 28'd20;
            10, 11: return 28'($urandom_range(0, 2000)) - 28'd1000;
            default: return 28'($urandom_range(0, 200000000)) - 28'(100000000);
        endcase
    endfunction

    task automatic add_word(logic [1:0] mode, longint na, longint da, longint nb,
                            longint db);
        t_operands w;
        w.mode = mode;
        w.na = na[27:0];
        w.da = da[27:0];
        w.nb = nb[27:0];
        w.db = db[27:0];
        pending_words.push_back(w);
    endtask

    // driver: bursts and gaps, holds the word while stalled
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (hold_for_drain && (expected_fractions.size() != 0 || i_valid)) begin
                    // a word accepted this edge is not yet counted, so keep waiting while i_valid is high
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    i_valid <= 1'b1;
                    {i_mode, i_num_a, i_den_a, i_num_b, i_den_b} <= pending_words.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (i_valid && !o_stall)
                expected_fractions.push_back(reduce_fraction(
                    {i_mode, i_num_a, i_den_a, i_num_b, i_den_b}));
        end
    end

    // monitor: own stall pattern, compares each word with the oldest expectation
    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(0, 7) < ((cycle_count / 5000) % 4)) ? 1'b1 : 1'b0;
            if (o_valid && !i_stall) begin
                if (expected_fractions.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected word num=%h den=%h status=%0d",
                                 o_res_num, o_res_den, o_status);
                end else begin
                    want = expected_fractions.pop_front();
                    if (want != {o_res_num, o_res_den, o_status}) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected %h/%h st %0d, got %h/%h st %0d",
                                     want.num, want.den, want.status,
                                     o_res_num, o_res_den, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("fraction_arith_reduce_unit test failed");
            $finish;
        end
    end

    initial begin
        int k;
        // directed: each operation, range limits, zero numerator and zero denominator
        add_word(far_pkg::ModeAdd, 1, 2, 1, 3);
        add_word(far_pkg::ModeSub, 1, 2, 1, 2);
        add_word(far_pkg::ModeMul, -6, 4, 2, -9);
        add_word(far_pkg::ModeDiv, 3, 4, 9, 8);
        add_word(far_pkg::ModeAdd, MaxMag, MaxMag, -MaxMag, -MaxMag);
        add_word(far_pkg::ModeMul, MaxMag, 1, MaxMag, 1);
        add_word(far_pkg::ModeDiv, -MaxMag, 7, 1, MaxMag);
        add_word(far_pkg::ModeAdd, MaxMag + 1, 1, 1, 1);
        add_word(far_pkg::ModeSub, 1, -MaxMag - 1, 1, 1);
        add_word(far_pkg::ModeMul, 1, 1, 134217727, 1);
        add_word(far_pkg::ModeDiv, 1, 1, 1, -134217728);
        add_word(far_pkg::ModeMul, 0, 0, 5, 7);
        add_word(far_pkg::ModeAdd, 0, 0, 0, 0);
        add_word(far_pkg::ModeDiv, 5, 3, 0, 2);
        add_word(far_pkg::ModeMul, 5, 0, 3, 2);
        add_word(far_pkg::ModeAdd, 1, 0, 1, 3);
        add_word(far_pkg::ModeSub, 99999989, 99999971, 99999959, 99999941);
        add_word(far_pkg::ModeMul, 1, -1, -1, 1);
        for (k = 0; k < 1500; k++) begin
            t_operands w;
            w.mode = 2'($urandom_range(0, 3));
            w.na = pick_operand();
            w.da = pick_operand();
            w.nb = pick_operand();
            w.db = pick_operand();
            pending_words.push_back(w);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // part way through, let the unit drain completely once
        wait (pending_words.size() < 1000);
        @(posedge i_clk);
        hold_for_drain <= 1'b1;
        wait (expected_fractions.size() == 0 && !i_valid);
        repeat (20) @(posedge i_clk);
        hold_for_drain <= 1'b0;
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        wait (!i_valid);
        wait (expected_fractions.size() == 0);
        repeat (TailCycles) @(posedge i_clk);
        if (mismatch_count == 0 && expected_fractions.size() == 0)
            $display("fraction_arith_reduce_unit test passed");
        else
            $display("fraction_arith_reduce_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
